FILE: rtl/ccs_pkg.sv
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types and codes for the capacitor charge sequencer.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int unsigned VOLT_W  = 16;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    // controller phases
    typedef enum logic [2:0] {
        PH_INIT        = 3'd0,
        PH_IDLE        = 3'd1,
        PH_CHARGING    = 3'd2,
        PH_CHARGED     = 3'd3,
        PH_DISCHARGING = 3'd4
    } phase_t;

    // host command codes, code 3 acts as none
    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_CHARGE    = 2'd1;
    localparam logic [1:0] CMD_DISCHARGE = 2'd2;

    // register indexes
    localparam logic [2:0] REG_TARGET      = 3'd0;
    localparam logic [2:0] REG_BAND        = 3'd1;
    localparam logic [2:0] REG_CHARGE_TIME = 3'd2;
    localparam logic [2:0] REG_HOLD_TIME   = 3'd3;
    localparam logic [2:0] REG_SAFE        = 3'd4;

    typedef struct packed {
        logic [VOLT_W-1:0]  target_voltage;
        logic [VOLT_W-1:0]  band_half_width;
        logic [TIMER_W-1:0] charge_time_limit;
        logic [TIMER_W-1:0] hold_time_limit;
        logic [VOLT_W-1:0]  safe_voltage;
    } cfg_t;

    typedef struct packed {
        phase_t             phase;
        logic               supply;
        logic               relay;
        logic [TIMER_W-1:0] timer_count;
        logic               timer_armed;
        logic               timeout_pending;
    } state_t;

endpackage

FILE: rtl/ccs_apb_regs.sv
// ----------------------------------------------------------------------------
// ccs_apb_regs
// APB register bank holding the sequencer thresholds and time limits.
// ----------------------------------------------------------------------------
module ccs_apb_regs
    import ccs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_voltage    <= '0;
            cfg_reg.band_half_width   <= '0;
            cfg_reg.charge_time_limit <= '1;
            cfg_reg.hold_time_limit   <= '1;
            cfg_reg.safe_voltage      <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_TARGET:      cfg_reg.target_voltage    <= pwdata[VOLT_W-1:0];
                REG_BAND:        cfg_reg.band_half_width   <= pwdata[VOLT_W-1:0];
                REG_CHARGE_TIME: cfg_reg.charge_time_limit <= pwdata[TIMER_W-1:0];
                REG_HOLD_TIME:   cfg_reg.hold_time_limit   <= pwdata[TIMER_W-1:0];
                REG_SAFE:        cfg_reg.safe_voltage      <= pwdata[VOLT_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_TARGET:      prdata = {{(DATA_W-VOLT_W){1'b0}}, cfg_reg.target_voltage};
            REG_BAND:        prdata = {{(DATA_W-VOLT_W){1'b0}}, cfg_reg.band_half_width};
            REG_CHARGE_TIME: prdata = {{(DATA_W-TIMER_W){1'b0}}, cfg_reg.charge_time_limit};
            REG_HOLD_TIME:   prdata = {{(DATA_W-TIMER_W){1'b0}}, cfg_reg.hold_time_limit};
            REG_SAFE:        prdata = {{(DATA_W-VOLT_W){1'b0}}, cfg_reg.safe_voltage};
            default:         prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/ccs_step_logic.sv
// ----------------------------------------------------------------------------
// ccs_step_logic
// Next-state logic for one controller step: timer, phase action and exits.
// ----------------------------------------------------------------------------
module ccs_step_logic
    import ccs_pkg::*;
(
    input  cfg_t              cfg,
    input  state_t            state_cur,
    input  logic [1:0]        command,
    input  logic [VOLT_W-1:0] capacitor_voltage,
    input  logic              timer_tick,
    output state_t            state_next
);

    logic [VOLT_W:0] volt_plus_band;
    logic [VOLT_W:0] target_ext;
    logic [VOLT_W:0] volt_ext;
    logic [VOLT_W:0] upper_bound;
    logic            below_lo;
    logic            above_lo;
    logic            below_hi;
    logic            above_hi;

    // band tests without a signed lower bound: volt < t-b  <=>  volt+b < t
    assign volt_ext       = {1'b0, capacitor_voltage};
    assign target_ext     = {1'b0, cfg.target_voltage};
    assign volt_plus_band = volt_ext + {1'b0, cfg.band_half_width};
    assign upper_bound    = target_ext + {1'b0, cfg.band_half_width};
    assign below_lo       = volt_plus_band < target_ext;
    assign above_lo       = volt_plus_band > target_ext;
    assign below_hi       = volt_ext < upper_bound;
    assign above_hi       = volt_ext > upper_bound;

    always_comb
    begin
        state_next = state_cur;

        // timer tick first
        if (timer_tick && state_cur.timer_armed)
        begin
            if (state_cur.timer_count <= TIMER_W'(1))
            begin
                state_next.timeout_pending = 1'b1;
                state_next.timer_count     = '0;
                state_next.timer_armed     = 1'b0;
            end
            else
            begin
                state_next.timer_count = state_cur.timer_count - TIMER_W'(1);
            end
        end

        case (state_cur.phase)
            PH_IDLE:
            begin
                state_next.supply = 1'b0;
                state_next.relay  = 1'b0;
                if (command == CMD_CHARGE)
                begin
                    state_next.timer_count = cfg.charge_time_limit;
                    state_next.timer_armed = 1'b1;
                    state_next.phase       = PH_CHARGING;
                end
            end
            PH_CHARGING:
            begin
                if (below_lo)
                begin
                    state_next.supply = 1'b1;
                    state_next.relay  = 1'b1;
                end
                if (above_hi)
                begin
                    state_next.supply = 1'b0;
                    state_next.relay  = 1'b0;
                end
                if (above_lo && below_hi)
                begin
                    state_next.timer_count = cfg.hold_time_limit;
                    state_next.timer_armed = 1'b1;
                    state_next.phase       = PH_CHARGED;
                end
                else
                begin
                    // pending timeout is consumed here
                    if (command == CMD_DISCHARGE || state_next.timeout_pending)
                    begin
                        state_next.timer_count = '0;
                        state_next.timer_armed = 1'b0;
                        state_next.phase       = PH_DISCHARGING;
                    end
                    state_next.timeout_pending = 1'b0;
                end
            end
            PH_CHARGED:
            begin
                state_next.supply = 1'b0;
                state_next.relay  = 1'b1;
                if (command == CMD_DISCHARGE || state_next.timeout_pending)
                begin
                    state_next.timer_count = '0;
                    state_next.timer_armed = 1'b0;
                    state_next.phase       = PH_DISCHARGING;
                end
                state_next.timeout_pending = 1'b0;
            end
            PH_DISCHARGING:
            begin
                state_next.supply = 1'b0;
                state_next.relay  = 1'b0;
                if (capacitor_voltage < cfg.safe_voltage)
                begin
                    state_next.phase = PH_IDLE;
                end
            end
            default:
            begin
                // initial phase and unused codes go idle, latches held
                state_next.phase = PH_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/capacitor_charge_sequencer.sv
// ----------------------------------------------------------------------------
// capacitor_charge_sequencer
// Capacitor charge controller: one controller step per input item.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid / in_ready  | command, capacitor_voltage, timer_tick
//  output   | out_valid / out_ready| phase, supply_on, relay_open
//  config   | apb psel/penable     | paddr, pwdata, prdata (5 regs at 4*i)
//
//  one item per clock sustained while the output is not stalled; an item's
//  result reaches the output through the input register, then step logic
//  into the result register
//  the controller state is updated in the same cycle the result is registered,
//  so consecutive items see each other's state with no gap
//  reset: state returns to the initial phase, latches and timer cleared,
//  limits set to full scale, thresholds to zero
//  a stalled output holds the result register and backs up into the input
//  register; in_ready stays high while either register can move
// ----------------------------------------------------------------------------
module capacitor_charge_sequencer
    import ccs_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // input item channel
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        command,
    input  logic [VOLT_W-1:0] capacitor_voltage,
    input  logic              timer_tick,
    // result item channel
    output logic              out_valid,
    input  logic              out_ready,
    output logic [2:0]        phase,
    output logic              supply_on,
    output logic              relay_open,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t              cfg;
    state_t            state_reg;
    state_t            state_next;

    // input register
    logic              in_valid_reg;
    logic [1:0]        command_reg;
    logic [VOLT_W-1:0] voltage_reg;
    logic              tick_reg;

    // result register
    logic              out_valid_reg;
    logic [2:0]        phase_out_reg;
    logic              supply_out_reg;
    logic              relay_out_reg;

    logic              advance;

    // step fires when the result register is free or being emptied
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;

    ccs_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ccs_step_logic u_step (
        .cfg               (cfg),
        .state_cur         (state_reg),
        .command           (command_reg),
        .capacitor_voltage (voltage_reg),
        .timer_tick        (tick_reg),
        .state_next        (state_next)
    );

    // handshake control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // controller state, updated once per stepped item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase           <= PH_INIT;
            state_reg.supply          <= 1'b0;
            state_reg.relay           <= 1'b0;
            state_reg.timer_count     <= '0;
            state_reg.timer_armed     <= 1'b0;
            state_reg.timeout_pending <= 1'b0;
        end
        else if (advance && in_valid_reg)
        begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            command_reg <= command;
            voltage_reg <= capacitor_voltage;
            tick_reg    <= timer_tick;
        end
        if (advance && in_valid_reg)
        begin
            phase_out_reg  <= state_next.phase;
            supply_out_reg <= state_next.supply;
            relay_out_reg  <= state_next.relay;
        end
    end

    assign out_valid  = out_valid_reg;
    assign phase      = phase_out_reg;
    assign supply_on  = supply_out_reg;
    assign relay_open = relay_out_reg;

endmodule
